// ===== rtl/mu8_pkg.sv =====
package mu8_pkg;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_BAD_LEAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic [15:0] error_offset;
    logic        end_of_string;
  } result_t;

  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [1:0] CONT_TAG    = 2'b10;
  localparam logic [1:0] PEND_TWO    = 2'd2;

endpackage

// ===== rtl/modified_utf8_decoder_unit.sv =====
// modified utf-8 decoder, one string payload byte per transaction
//
// in channel: in_tdata carries one payload byte, in_tlast marks the last byte
// of the string. out channel: one decoded 16-bit code unit or one error per
// transaction; out_tuser gives the status (character, truncated, bad
// continuation, bad lead), out_tlast closes the string. multi-byte lead bytes
// not at string end and bytes dropped after an error give no transaction.
//
// a byte accepted passes the input register, then the decode logic feeding
// the result register, from which its result shows. throughput: one byte per
// cycle unless out_tready stalls a held result; the decode state update is a
// single pass of logic between the input register and the result register.
//
// reset clears the sequence state, the byte offset and both pipeline valids.
// when the receiver holds out_tready low the result stays in place, one more
// byte waits in the input register, and in_tready then drops until the result
// is taken.
module modified_utf8_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] code_unit, [31:16] error_offset
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // end_of_string
);

  // input register
  logic        in_vld_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // decode state
  logic [1:0]  pend_r,    pend_nxt;
  logic [15:0] part_r,    part_nxt;
  logic [15:0] lead_r,    lead_nxt;
  logic [15:0] cnt_r,     cnt_nxt;
  logic        cbad_r,    cbad_nxt;
  logic        drop_r,    drop_nxt;

  // result register
  logic              out_vld_r;
  mu8_pkg::result_t  res_r;
  mu8_pkg::result_t  res_nxt;
  logic              emit;

  logic        advance;
  logic        bad_now;
  logic [15:0] part_or;
  logic [1:0]  pend_dec;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_comb begin
    bad_now  = cbad_r || (byte_r[7:6] != mu8_pkg::CONT_TAG);
    part_or  = part_r | ((pend_r == mu8_pkg::PEND_TWO) ? {4'b0, byte_r[5:0], 6'b0}
                                                        : {10'b0, byte_r[5:0]});
    pend_dec = pend_r - 2'd1;

    pend_nxt = pend_r;
    part_nxt = part_r;
    lead_nxt = lead_r;
    cbad_nxt = cbad_r;
    drop_nxt = drop_r;
    cnt_nxt  = last_r ? 16'd0 : cnt_r + 16'd1;

    emit    = 1'b0;
    res_nxt = '{code_unit: 16'd0, status: mu8_pkg::ST_CHAR,
                error_offset: 16'd0, end_of_string: last_r};

    if (drop_r) begin
      if (last_r) drop_nxt = 1'b0;
    end else if (pend_r == 2'd0) begin
      if (!byte_r[7]) begin
        emit = 1'b1;
        res_nxt.code_unit = {8'b0, byte_r};
      end else if ((byte_r & mu8_pkg::LEAD2_MASK) == mu8_pkg::LEAD2_CODE ||
                   (byte_r & mu8_pkg::LEAD3_MASK) == mu8_pkg::LEAD3_CODE) begin
        if (last_r) begin
          emit = 1'b1;
          res_nxt.status = mu8_pkg::ST_TRUNC;
        end else begin
          lead_nxt = cnt_r;
          cbad_nxt = 1'b0;
          if ((byte_r & mu8_pkg::LEAD2_MASK) == mu8_pkg::LEAD2_CODE) begin
            pend_nxt = 2'd1;
            part_nxt = {5'b0, byte_r[4:0], 6'b0};
          end else begin
            pend_nxt = mu8_pkg::PEND_TWO;
            part_nxt = {byte_r[3:0], 12'b0};
          end
        end
      end else begin
        emit = 1'b1;
        res_nxt.status       = mu8_pkg::ST_BAD_LEAD;
        res_nxt.error_offset = cnt_r;
        if (!last_r) drop_nxt = 1'b1;
      end
    end else begin
      if (pend_dec == 2'd0) begin
        emit = 1'b1;
        if (bad_now) begin
          res_nxt.status       = mu8_pkg::ST_BAD_CONT;
          res_nxt.error_offset = lead_r + 16'd2;
          if (!last_r) drop_nxt = 1'b1;
        end else begin
          res_nxt.code_unit = part_or;
        end
        pend_nxt = 2'd0;
        part_nxt = 16'd0;
        lead_nxt = 16'd0;
        cbad_nxt = 1'b0;
      end else begin
        pend_nxt = pend_dec;
        part_nxt = part_or;
        cbad_nxt = bad_now;
        if (last_r) begin
          emit = 1'b1;
          res_nxt.status = mu8_pkg::ST_TRUNC;
        end
      end
    end

    // every string end starts the next one clean
    if (last_r) begin
      pend_nxt = 2'd0;
      part_nxt = 16'd0;
      lead_nxt = 16'd0;
      cbad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= 16'd0;
      lead_r <= 16'd0;
      cnt_r  <= 16'd0;
      cbad_r <= 1'b0;
      drop_r <= 1'b0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      lead_r <= lead_nxt;
      cnt_r  <= cnt_nxt;
      cbad_r <= cbad_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= emit;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.error_offset, res_r.code_unit};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.end_of_string;

`ifndef NO_ASSERTIONS
  a_err_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status != mu8_pkg::ST_CHAR |-> res_r.code_unit == 16'd0)
    else $error("error result carries a nonzero code unit");

  a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.status == mu8_pkg::ST_CHAR || res_r.status == mu8_pkg::ST_TRUNC)
    |-> res_r.error_offset == 16'd0)
    else $error("offset set on a result that has none");

  a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status == mu8_pkg::ST_TRUNC |-> res_r.end_of_string)
    else $error("truncation reported before string end");

  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> pend_r == 2'd0 && !cbad_r)
    else $error("sequence still open while dropping");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("pending count out of range");
`endif

endmodule
